### rtl/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants for the multiturn encoder unwrapper.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ANGLE_W      = 40;
  localparam int HALF_TURNS_W = 16;

  localparam logic signed [HALF_TURNS_W-1:0] HC_MAX = 16'sh7FFF;
  localparam logic signed [HALF_TURNS_W-1:0] HC_MIN = 16'sh8000;

  typedef enum logic {
    OP_MEASURE   = 1'b0,
    OP_CALIBRATE = 1'b1
  } op_t;

  // frame kind and the middle flag that goes with it
  typedef struct packed {
    logic calib;
    logic mid;
  } frame_ctl_t;

endpackage

### rtl/mte_if.sv
// ----------------------------------------------------------------------------
// mte_in_if / mte_out_if
// Valid/ready channels for encoder words in and unwrapped angles out.
// ----------------------------------------------------------------------------
interface mte_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [mte_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, op, sample, input ready);
  modport sink   (input valid, op, sample, output ready);
endinterface

interface mte_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mte_pkg::ANGLE_W-1:0]      angle_deg;
  logic signed [mte_pkg::HALF_TURNS_W-1:0] half_turns;
  logic                                    in_middle;

  modport source (output valid, angle_deg, half_turns, in_middle, input ready);
  modport sink   (input valid, angle_deg, half_turns, in_middle, output ready);
endinterface

### rtl/mte_fifo.sv
// ----------------------------------------------------------------------------
// mte_fifo
// Two-entry queue of frame records between the front and back ends.
// ----------------------------------------------------------------------------
module mte_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;

  assign full_o  = (cnt_r == 2'(DEPTH));
  assign empty_o = (cnt_r == 2'd0);
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_i) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("frame queue read while empty");

endmodule

### rtl/mte_front.sv
// ----------------------------------------------------------------------------
// mte_front
// Frame tracking: picks subsamples, votes, sums raw and half-turn-shifted
// words and hands one record per frame to the queue.
// ----------------------------------------------------------------------------
module mte_front #(
  parameter int SUBSAMPLES = 12,
  parameter int STRIDE     = 4,
  parameter int TURN_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic [mte_pkg::SAMPLE_W-1:0]          in_sample,
  input  logic                                  full_i,
  output logic                                  push_o,
  output mte_pkg::frame_ctl_t                   rec_ctl_o,
  output logic [TURN_BITS-1:0]                  rec_first_o,
  output logic [TURN_BITS+$clog2(SUBSAMPLES)-1:0] rec_sum_o
);

  localparam int PW     = (TURN_BITS > mte_pkg::SAMPLE_W) ? TURN_BITS : mte_pkg::SAMPLE_W;
  localparam int SUM_W  = TURN_BITS + $clog2(SUBSAMPLES);
  localparam int SUB_W  = $clog2(SUBSAMPLES);
  localparam int PH_W   = (STRIDE > 1) ? $clog2(STRIDE) : 1;
  localparam int VOTE_W = $clog2(SUBSAMPLES + 1);
  localparam logic [TURN_BITS-1:0] QUARTER = {2'b01, {(TURN_BITS-2){1'b0}}};
  localparam logic [TURN_BITS-1:0] THREE_Q = {2'b11, {(TURN_BITS-2){1'b0}}};

  logic [SUB_W-1:0]     sub_r;
  logic [PH_W-1:0]      ph_r;
  logic                 calib_r;
  logic [TURN_BITS-1:0] first_r;
  logic [SUM_W-1:0]     raw_r;
  logic [SUM_W-1:0]     shf_r;
  logic [VOTE_W-1:0]    votes_r;

  logic [SUB_W-1:0]     sub_nxt;
  logic [PH_W-1:0]      ph_nxt;
  logic                 calib_nxt;
  logic [TURN_BITS-1:0] first_nxt;
  logic [SUM_W-1:0]     raw_nxt;
  logic [SUM_W-1:0]     shf_nxt;
  logic [VOTE_W-1:0]    votes_nxt;

  logic [PW-1:0]        pad;
  logic [TURN_BITS-1:0] smp;
  logic [TURN_BITS-1:0] smp_shf;
  logic                 smp_mid;
  logic                 at_start;
  logic                 at_tap;
  logic                 at_last;
  logic                 acc;
  logic                 vote_mid;
  logic                 first_mid;

  assign pad     = PW'(in_sample);
  assign smp     = pad[TURN_BITS-1:0];
  // adding half a turn modulo one turn only flips the top bit
  assign smp_shf = {~smp[TURN_BITS-1], smp[TURN_BITS-2:0]};
  assign smp_mid = (smp > QUARTER) && (smp < THREE_Q);

  assign at_start = (sub_r == '0) && (ph_r == '0);
  assign at_tap   = (ph_r == '0);
  assign at_last  = (sub_r == SUB_W'(SUBSAMPLES - 1)) && (ph_r == PH_W'(STRIDE - 1));

  assign in_ready = !(at_last && full_i);
  assign acc      = in_valid && in_ready;
  assign push_o   = acc && at_last;

  always_comb begin
    calib_nxt = at_start ? (mte_pkg::op_t'(in_op) == mte_pkg::OP_CALIBRATE) : calib_r;
    first_nxt = at_start ? smp : first_r;
    raw_nxt   = at_start ? '0 : raw_r;
    shf_nxt   = at_start ? '0 : shf_r;
    votes_nxt = at_start ? '0 : votes_r;
    if (at_tap) begin
      raw_nxt   = raw_nxt + SUM_W'(smp);
      shf_nxt   = shf_nxt + SUM_W'(smp_shf);
      votes_nxt = votes_nxt + VOTE_W'(smp_mid);
    end
    if (ph_r == PH_W'(STRIDE - 1)) begin
      ph_nxt  = '0;
      sub_nxt = (sub_r == SUB_W'(SUBSAMPLES - 1)) ? '0 : sub_r + SUB_W'(1);
    end else begin
      ph_nxt  = ph_r + PH_W'(1);
      sub_nxt = sub_r;
    end
  end

  // tie counts as outside
  assign vote_mid  = {votes_nxt, 1'b0} > (VOTE_W+1)'(SUBSAMPLES);
  assign first_mid = (first_nxt > QUARTER) && (first_nxt < THREE_Q);

  assign rec_ctl_o.calib = calib_nxt;
  assign rec_ctl_o.mid   = calib_nxt ? first_mid : vote_mid;
  assign rec_first_o     = first_nxt;
  assign rec_sum_o       = (calib_nxt || vote_mid) ? raw_nxt : shf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
      ph_r  <= '0;
    end else if (acc) begin
      sub_r <= sub_nxt;
      ph_r  <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      calib_r <= calib_nxt;
      first_r <= first_nxt;
      raw_r   <= raw_nxt;
      shf_r   <= shf_nxt;
      votes_r <= votes_nxt;
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && at_last |=> (sub_r == '0) && (ph_r == '0))
    else $error("frame position did not wrap after last item");

endmodule

### rtl/mte_back.sv
// ----------------------------------------------------------------------------
// mte_back
// Per-frame pipeline: mean by reciprocal multiply, half-turn counter and
// offset update, conversion to fixed-point degrees and output register.
// ----------------------------------------------------------------------------
module mte_back #(
  parameter int SUBSAMPLES = 12,
  parameter int TURN_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    empty_i,
  output logic                                    pop_o,
  input  mte_pkg::frame_ctl_t                     ctl_i,
  input  logic [TURN_BITS-1:0]                    first_i,
  input  logic [TURN_BITS+$clog2(SUBSAMPLES)-1:0] sum_i,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mte_pkg::ANGLE_W-1:0]      out_angle_deg,
  output logic signed [mte_pkg::HALF_TURNS_W-1:0] out_half_turns,
  output logic                                    out_in_middle
);

  localparam int SUM_W = TURN_BITS + $clog2(SUBSAMPLES);
  localparam int REM_W = $clog2(SUBSAMPLES);
  localparam int HW    = mte_pkg::HALF_TURNS_W;
  localparam int AW    = TURN_BITS + HW;
  localparam int XW    = AW + 1;
  localparam int WW    = XW + 10;
  localparam int FL    = (TURN_BITS < 16) ? 16 - TURN_BITS : 0;
  localparam int FR    = (TURN_BITS > 16) ? TURN_BITS - 16 : 0;
  localparam int GW    = (FL > 0) ? FL : 1;
  localparam int QW    = WW + FL;
  localparam int OW    = mte_pkg::ANGLE_W;
  localparam logic [SUM_W-1:0] RECIP    = SUM_W'((64'd1 << SUM_W) / SUBSAMPLES);
  localparam logic [SUM_W-1:0] SUM_HALF = SUM_W'(longint'(SUBSAMPLES) << (TURN_BITS - 1));
  localparam logic signed [QW-1:0] ANG_MAX = {{(QW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [QW-1:0] ANG_MIN = {{(QW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  // per remainder b: floor(360*b/S), and the fraction bits left over from
  // 360*b/S when the turn is narrower than 16 bits
  logic [8:0]               tb_tab [SUBSAMPLES];
  logic [GW-1:0]            g_tab  [SUBSAMPLES];

  for (genvar gi = 0; gi < SUBSAMPLES; gi++) begin : g_frac
    assign tb_tab[gi] = 9'((gi * 360) / SUBSAMPLES);
    assign g_tab[gi]  = GW'((((gi * 360) % SUBSAMPLES) << FL) / SUBSAMPLES);
  end

  logic en;

  // stage D1: reciprocal product
  logic                     d1_v_r;
  mte_pkg::frame_ctl_t      d1_ctl_r;
  logic [TURN_BITS-1:0]     d1_first_r;
  logic [SUM_W-1:0]         d1_sum_r;
  logic [2*SUM_W-1:0]       d1_prod_r;

  // stage D2: corrected quotient and remainder
  logic                     d2_v_r;
  mte_pkg::frame_ctl_t      d2_ctl_r;
  logic [TURN_BITS-1:0]     d2_first_r;
  logic [SUM_W-1:0]         d2_sum_r;
  logic [SUM_W-1:0]         d2_quo_r;
  logic [REM_W-1:0]         d2_rem_r;
  logic [SUM_W-1:0]         q0;
  logic [SUM_W-1:0]         rem0;
  logic                     fix;
  logic [SUM_W-1:0]         quo_nxt;
  logic [SUM_W-1:0]         rem_full;

  // stage U: frame state update
  logic                     prev_r;
  logic signed [HW-1:0]     hc_r;
  logic [TURN_BITS-1:0]     offset_r;
  logic                     prev_nxt;
  logic signed [HW-1:0]     hc_nxt;
  logic [TURN_BITS-1:0]     offset_nxt;
  logic                     step;
  logic                     up;
  logic signed [AW-1:0]     a_term_nxt;
  logic [TURN_BITS-1:0]     a_nxt;
  logic [REM_W-1:0]         b_nxt;
  logic                     u_v_r;
  logic [TURN_BITS-1:0]     u_a_r;
  logic [REM_W-1:0]         u_b_r;
  logic signed [AW-1:0]     u_aterm_r;
  logic signed [HW-1:0]     u_hc_r;
  logic                     u_mid_r;

  // stage O1 / O2: degree scaling
  logic                     o1_v_r;
  logic signed [XW-1:0]     o1_x_r;
  logic [8:0]               o1_tb_r;
  logic [GW-1:0]            o1_g_r;
  logic signed [HW-1:0]     o1_hc_r;
  logic                     o1_mid_r;
  logic signed [XW-1:0]     x_nxt;
  logic                     o2_v_r;
  logic signed [WW-1:0]     o2_w_r;
  logic [GW-1:0]            o2_g_r;
  logic signed [HW-1:0]     o2_hc_r;
  logic                     o2_mid_r;
  logic signed [WW-1:0]     xw;
  logic signed [WW-1:0]     w_nxt;
  logic signed [QW-1:0]     q;
  logic signed [OW-1:0]     angle_nxt;

  // output register
  logic                     out_valid_r;
  logic signed [OW-1:0]     angle_r;
  logic signed [HW-1:0]     hc_out_r;
  logic                     mid_out_r;

  // whole pipeline moves together; it halts only while a result waits
  assign en    = !out_valid_r || out_ready;
  assign pop_o = en && !empty_i;

  // D2 correction: reciprocal estimate is at most one low
  always_comb begin
    q0       = d1_prod_r[2*SUM_W-1:SUM_W];
    rem0     = d1_sum_r - SUM_W'(q0 * SUM_W'(SUBSAMPLES));
    fix      = (rem0 >= SUM_W'(SUBSAMPLES));
    quo_nxt  = q0 + SUM_W'(fix);
    rem_full = fix ? rem0 - SUM_W'(SUBSAMPLES) : rem0;
  end

  // U: counter, offset and the terms of the angle
  always_comb begin
    step       = (d2_ctl_r.mid != prev_r);
    up         = (d2_sum_r < SUM_HALF);
    prev_nxt   = d2_ctl_r.mid;
    offset_nxt = offset_r;
    hc_nxt     = hc_r;
    if (d2_ctl_r.calib) begin
      offset_nxt = d2_quo_r[TURN_BITS-1:0];
      hc_nxt     = '0;
    end else if (step && up && (hc_r != mte_pkg::HC_MAX)) begin
      hc_nxt = hc_r + HW'(1);
    end else if (step && !up && (hc_r != mte_pkg::HC_MIN)) begin
      hc_nxt = hc_r - HW'(1);
    end
    if (d2_ctl_r.calib) begin
      a_nxt      = d2_first_r;
      b_nxt      = '0;
      a_term_nxt = '0;
    end else begin
      a_nxt      = d2_quo_r[TURN_BITS-1:0];
      b_nxt      = d2_rem_r;
      a_term_nxt = ($signed({{(AW-HW){hc_nxt[HW-1]}}, hc_nxt}) <<< (TURN_BITS - 1))
                 - $signed({{(AW-TURN_BITS){1'b0}}, offset_r});
    end
  end

  // O1 / O2 / output: angle = (360*(a + A) + T(b)) scaled by the turn width
  assign x_nxt = $signed({{(XW-TURN_BITS){1'b0}}, u_a_r})
               + $signed({u_aterm_r[AW-1], u_aterm_r});
  assign xw    = $signed({{(WW-XW){o1_x_r[XW-1]}}, o1_x_r});
  assign w_nxt = (xw <<< 8) + (xw <<< 6) + (xw <<< 5) + (xw <<< 3)
               + $signed({{(WW-9){1'b0}}, o1_tb_r});

  always_comb begin
    q = (($signed({{(QW-WW){o2_w_r[WW-1]}}, o2_w_r}) <<< FL) >>> FR)
      + $signed({{(QW-GW){1'b0}}, o2_g_r});
    if (q > ANG_MAX) begin
      angle_nxt = ANG_MAX[OW-1:0];
    end else if (q < ANG_MIN) begin
      angle_nxt = ANG_MIN[OW-1:0];
    end else begin
      angle_nxt = q[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r      <= 1'b0;
      d2_v_r      <= 1'b0;
      u_v_r       <= 1'b0;
      o1_v_r      <= 1'b0;
      o2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= 1'b0;
      hc_r        <= '0;
      offset_r    <= '0;
    end else if (en) begin
      d1_v_r      <= !empty_i;
      d2_v_r      <= d1_v_r;
      u_v_r       <= d2_v_r;
      o1_v_r      <= u_v_r;
      o2_v_r      <= o1_v_r;
      out_valid_r <= o2_v_r;
      if (d2_v_r) begin
        prev_r   <= prev_nxt;
        hc_r     <= hc_nxt;
        offset_r <= offset_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_ctl_r   <= ctl_i;
      d1_first_r <= first_i;
      d1_sum_r   <= sum_i;
      d1_prod_r  <= (2*SUM_W)'(sum_i) * (2*SUM_W)'(RECIP);
      d2_ctl_r   <= d1_ctl_r;
      d2_first_r <= d1_first_r;
      d2_sum_r   <= d1_sum_r;
      d2_quo_r   <= quo_nxt;
      d2_rem_r   <= rem_full[REM_W-1:0];
      u_a_r      <= a_nxt;
      u_b_r      <= b_nxt;
      u_aterm_r  <= a_term_nxt;
      u_hc_r     <= hc_nxt;
      u_mid_r    <= prev_nxt;
      o1_x_r     <= x_nxt;
      o1_tb_r    <= tb_tab[u_b_r];
      o1_g_r     <= g_tab[u_b_r];
      o1_hc_r    <= u_hc_r;
      o1_mid_r   <= u_mid_r;
      o2_w_r     <= w_nxt;
      o2_g_r     <= o1_g_r;
      o2_hc_r    <= o1_hc_r;
      o2_mid_r   <= o1_mid_r;
      angle_r    <= angle_nxt;
      hc_out_r   <= o2_hc_r;
      mid_out_r  <= o2_mid_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_angle_deg  = angle_r;
  assign out_half_turns = hc_out_r;
  assign out_in_middle  = mid_out_r;

  a_calib_clears: assert property (@(posedge clk) disable iff (!rst_n)
    en && d2_v_r && d2_ctl_r.calib |=> (hc_r == '0) && (prev_r == $past(d2_ctl_r.mid)))
    else $error("calibrate frame did not clear the half-turn counter");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    en && d2_v_r && !d2_ctl_r.calib && (d2_ctl_r.mid == prev_r) |=> hc_r == $past(hc_r))
    else $error("half-turn counter moved without a change of vote");

endmodule

### rtl/multiturn_encoder_unwrap.sv
// ----------------------------------------------------------------------------
// multiturn_encoder_unwrap
// Unwraps a stream of absolute encoder words into a multiturn angle, one
// result per frame of SUBSAMPLES*STRIDE words.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   per
//  in_ch    in   op (1), sample (16)                       item
//  out_ch   out  angle_deg (s40), half_turns (s16), in_middle (1)  frame
//
//  One encoder word is taken every cycle; in_ch.ready falls only on the last
//  word of a frame while the two-entry frame queue is full.
//  The back end takes one frame record per cycle while no result waits on
//  out_ch.ready; a record passes D1, D2, U, O1, O2 and the output register.
//  A held result stalls the back end only; the front keeps filling the queue.
//  Reset (rst_n, synchronous) restarts the frame and clears counter, offset
//  and middle flag.
// ----------------------------------------------------------------------------
module multiturn_encoder_unwrap #(
  parameter int SUBSAMPLES = 12,
  parameter int STRIDE     = 4,
  parameter int TURN_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mte_in_if.sink    in_ch,
  mte_out_if.source out_ch
);

  localparam int SUM_W = TURN_BITS + $clog2(SUBSAMPLES);
  localparam int CTL_W = $bits(mte_pkg::frame_ctl_t);
  localparam int REC_W = CTL_W + TURN_BITS + SUM_W;

  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  mte_pkg::frame_ctl_t  wr_ctl;
  logic [TURN_BITS-1:0] wr_first;
  logic [SUM_W-1:0]     wr_sum;
  mte_pkg::frame_ctl_t  rd_ctl;
  logic [TURN_BITS-1:0] rd_first;
  logic [SUM_W-1:0]     rd_sum;
  logic [REC_W-1:0]     rd_rec;

  mte_front #(
    .SUBSAMPLES (SUBSAMPLES),
    .STRIDE     (STRIDE),
    .TURN_BITS  (TURN_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_op       (in_ch.op),
    .in_sample   (in_ch.sample),
    .full_i      (full),
    .push_o      (push),
    .rec_ctl_o   (wr_ctl),
    .rec_first_o (wr_first),
    .rec_sum_o   (wr_sum)
  );

  mte_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  ({wr_ctl, wr_first, wr_sum}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (rd_rec),
    .empty_o (empty)
  );

  assign rd_ctl   = mte_pkg::frame_ctl_t'(rd_rec[REC_W-1 -: CTL_W]);
  assign rd_first = rd_rec[SUM_W +: TURN_BITS];
  assign rd_sum   = rd_rec[SUM_W-1:0];

  mte_back #(
    .SUBSAMPLES (SUBSAMPLES),
    .TURN_BITS  (TURN_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty_i        (empty),
    .pop_o          (pop),
    .ctl_i          (rd_ctl),
    .first_i        (rd_first),
    .sum_i          (rd_sum),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_angle_deg  (out_ch.angle_deg),
    .out_half_turns (out_ch.half_turns),
    .out_in_middle  (out_ch.in_middle)
  );

endmodule

### tb/multiturn_encoder_unwrap_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiturn_encoder_unwrap_chk
// Watches both channels of the unwrapper, keeps its own copy of the frame
// state, predicts each frame's angle record and compares it with what comes
// out, in order.
// ----------------------------------------------------------------------------
module multiturn_encoder_unwrap_chk #(
  parameter int SUBSAMPLES = 12,
  parameter int STRIDE     = 4,
  parameter int TURN_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  mte_in_if    in_ch,
  mte_out_if   out_ch,
  output int   mismatches,
  output int   pending,
  output int   results_seen
);

  localparam int    FRAME_LEN = SUBSAMPLES * STRIDE;
  localparam int    POS_W     = $clog2(FRAME_LEN);
  localparam int    SUM_W     = TURN_BITS + 4;
  localparam longint HALF     = longint'(1) << (TURN_BITS - 1);
  localparam longint QUARTER  = longint'(1) << (TURN_BITS - 2);

  typedef struct packed {
    logic signed [mte_pkg::ANGLE_W-1:0]      angle;
    logic signed [mte_pkg::HALF_TURNS_W-1:0] turns;
    logic                                    mid;
  } unwrap_rec_t;

  unwrap_rec_t unwrap_q[$];

  // shadow of the block's state
  logic                                    prev_mid;
  logic signed [mte_pkg::HALF_TURNS_W-1:0] turn_cnt;
  logic [TURN_BITS-1:0]                    cal_offset;
  logic [SUM_W-1:0]                        raw_acc;
  logic [SUM_W-1:0]                        shifted_acc;
  logic [4:0]                              mid_votes;
  logic [POS_W-1:0]                        frame_pos;
  logic                                    frame_cal;
  logic [TURN_BITS-1:0]                    frame_first;

  function automatic logic word_is_mid(input logic [TURN_BITS-1:0] s);
    return longint'(s) > QUARTER && longint'(s) < 3 * QUARTER;
  endfunction

  // counts*SUBSAMPLES -> degrees, 16 fraction bits, floor, saturated
  function automatic logic signed [mte_pkg::ANGLE_W-1:0] to_fixed_deg(input longint num);
    longint n;
    longint d;
    longint q;
    longint lim;
    lim = longint'(1) << (mte_pkg::ANGLE_W - 1);
    if (TURN_BITS <= 16) begin
      n = num * 360 * (longint'(1) << (16 - TURN_BITS));
      d = SUBSAMPLES;
    end else begin
      n = num * 360;
      d = longint'(SUBSAMPLES) << (TURN_BITS - 16);
    end
    if (n >= 0) q = n / d;
    else q = -((-n + d - 1) / d);
    if (q > lim - 1) q = lim - 1;
    if (q < -lim) q = -lim;
    return q[mte_pkg::ANGLE_W-1:0];
  endfunction

  task automatic take_word(input logic op, input logic [mte_pkg::SAMPLE_W-1:0] word);
    logic [TURN_BITS-1:0] s;
    logic [TURN_BITS-1:0] sh;
    logic [SUM_W-1:0]     sum;
    logic                 m;
    longint               num;
    unwrap_rec_t          rec;
    s = TURN_BITS'(word);
    if (frame_pos == 0) begin
      frame_cal   = (mte_pkg::op_t'(op) == mte_pkg::OP_CALIBRATE);
      frame_first = s;
      raw_acc     = '0;
      shifted_acc = '0;
      mid_votes   = '0;
    end
    if (int'(frame_pos) % STRIDE == 0) begin
      sh = TURN_BITS'(longint'(s) + HALF);
      raw_acc     = raw_acc + SUM_W'(s);
      shifted_acc = shifted_acc + SUM_W'(sh);
      if (word_is_mid(s)) mid_votes = mid_votes + 5'd1;
    end
    if (int'(frame_pos) + 1 < FRAME_LEN) begin
      frame_pos = frame_pos + POS_W'(1);
      return;
    end
    frame_pos = '0;

    if (frame_cal) begin
      m          = word_is_mid(frame_first);
      cal_offset = TURN_BITS'(raw_acc / SUBSAMPLES);
      prev_mid   = m;
      turn_cnt   = '0;
      rec.angle  = to_fixed_deg(longint'(frame_first) * SUBSAMPLES);
    end else begin
      m   = (2 * int'(mid_votes) > SUBSAMPLES);
      sum = m ? raw_acc : shifted_acc;
      if (m != prev_mid) begin
        if (longint'(sum) < SUBSAMPLES * HALF) begin
          if (turn_cnt != mte_pkg::HC_MAX) turn_cnt = turn_cnt + 16'sd1;
        end else begin
          if (turn_cnt != mte_pkg::HC_MIN) turn_cnt = turn_cnt - 16'sd1;
        end
      end
      prev_mid = m;
      num = longint'(sum) - SUBSAMPLES * longint'(cal_offset)
          + SUBSAMPLES * longint'(turn_cnt) * HALF;
      rec.angle = to_fixed_deg(num);
    end
    rec.turns = turn_cnt;
    rec.mid   = m;
    unwrap_q.push_back(rec);
  endtask

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    unwrap_rec_t want;
    if (!rst_n) begin
      prev_mid    = 1'b0;
      turn_cnt    = '0;
      cal_offset  = '0;
      raw_acc     = '0;
      shifted_acc = '0;
      mid_votes   = '0;
      frame_pos   = '0;
      frame_cal   = 1'b0;
      frame_first = '0;
      unwrap_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (unwrap_q.size() == 0) begin
          note_mismatch($sformatf("result transaction with none pending (angle %0d)",
                                  out_ch.angle_deg));
        end else begin
          want = unwrap_q.pop_front();
          if (out_ch.angle_deg !== want.angle)
            note_mismatch($sformatf("result %0d angle_deg %0d, want %0d",
                                    results_seen, out_ch.angle_deg, want.angle));
          if (out_ch.half_turns !== want.turns)
            note_mismatch($sformatf("result %0d half_turns %0d, want %0d",
                                    results_seen, out_ch.half_turns, want.turns));
          if (out_ch.in_middle !== want.mid)
            note_mismatch($sformatf("result %0d in_middle %0b, want %0b",
                                    results_seen, out_ch.in_middle, want.mid));
        end
      end
      if (in_ch.valid && in_ch.ready) take_word(in_ch.op, in_ch.sample);
    end
    pending = unwrap_q.size();
  end

endmodule

### tb/multiturn_encoder_unwrap_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiturn_encoder_unwrap_tb
// Drives frames of encoder words into the unwrapper: a directed set of
// boundary and vote cases, then rotating-shaft trajectories mixed with noise
// frames and recalibrations, most of them under random gaps and output stalls.
// ----------------------------------------------------------------------------
module multiturn_encoder_unwrap_tb;

  localparam int SUBSAMPLES   = 12;
  localparam int STRIDE       = 4;
  localparam int TURN_BITS    = 16;
  localparam int FRAME_LEN    = SUBSAMPLES * STRIDE;
  localparam int RAND_FRAMES  = 22;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid  = 1'b0;
  logic                         in_op     = 1'b0;
  logic [mte_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                         out_ready = 1'b0;

  logic steady = 1'b1;
  int   ready_hold = 0;
  int   cycles = 0;
  int   frames_sent = 0;
  int   cal_frames = 0;

  int mismatches;
  int pending;
  int results_seen;

  mte_in_if  in_ch ();
  mte_out_if out_ch ();

  assign in_ch.valid  = in_valid;
  assign in_ch.op     = in_op;
  assign in_ch.sample = in_sample;
  assign out_ch.ready = out_ready;

  multiturn_encoder_unwrap #(
    .SUBSAMPLES (SUBSAMPLES),
    .STRIDE     (STRIDE),
    .TURN_BITS  (TURN_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  multiturn_encoder_unwrap_chk #(
    .SUBSAMPLES (SUBSAMPLES),
    .STRIDE     (STRIDE),
    .TURN_BITS  (TURN_BITS)
  ) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(12, 70);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= !out_ready;
      ready_hold <= out_ready ? stall_len() : $urandom_range(0, 25);
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input mte_pkg::op_t op,
                           input logic [mte_pkg::SAMPLE_W-1:0] word);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_sample <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // op only matters on the first word; elsewhere it is junk, as are the
  // words between subsamples
  task automatic send_frame(input mte_pkg::op_t op,
                            input logic [mte_pkg::SAMPLE_W-1:0] subs [SUBSAMPLES]);
    mte_pkg::op_t junk_op;
    for (int i = 0; i < FRAME_LEN; i++) begin
      junk_op = mte_pkg::op_t'($urandom_range(0, 1));
      if (i % STRIDE == 0)
        send_word((i == 0) ? op : junk_op, subs[i / STRIDE]);
      else
        send_word(junk_op, mte_pkg::SAMPLE_W'($urandom_range(0, 65535)));
    end
    frames_sent++;
    if (op == mte_pkg::OP_CALIBRATE) cal_frames++;
  endtask

  initial begin
    logic [mte_pkg::SAMPLE_W-1:0] subs [SUBSAMPLES];
    int           shaft;
    int           rate;
    int           kind;
    int           drain;
    mte_pkg::op_t op;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // calibrate on the lower quarter boundary, rest at the word extremes
    for (int k = 0; k < SUBSAMPLES; k++)
      subs[k] = (k == 0) ? 16'd16384 : ((k % 2) ? 16'hFFFF : 16'h0000);
    send_frame(mte_pkg::OP_CALIBRATE, subs);
    for (int k = 0; k < SUBSAMPLES; k++) subs[k] = 16'hFFFF;
    send_frame(mte_pkg::OP_MEASURE, subs);
    // even split of votes: counts as outside
    for (int k = 0; k < SUBSAMPLES; k++)
      subs[k] = (k < SUBSAMPLES / 2) ? 16'd16385 : 16'd49152;
    send_frame(mte_pkg::OP_MEASURE, subs);
    // one vote over half: middle, counter moves
    for (int k = 0; k < SUBSAMPLES; k++)
      subs[k] = (k <= SUBSAMPLES / 2) ? 16'd49151 : 16'd0;
    send_frame(mte_pkg::OP_MEASURE, subs);
    for (int k = 0; k < SUBSAMPLES; k++) subs[k] = (k % 2) ? 16'd32768 : 16'd32767;
    send_frame(mte_pkg::OP_MEASURE, subs);
    for (int k = 0; k < SUBSAMPLES; k++) subs[k] = 16'd0;
    send_frame(mte_pkg::OP_MEASURE, subs);
    for (int k = 0; k < SUBSAMPLES; k++) subs[k] = (k == 0) ? 16'd32768 : 16'd16383;
    send_frame(mte_pkg::OP_CALIBRATE, subs);
    for (int k = 0; k < SUBSAMPLES; k++) subs[k] = 16'd0;
    send_frame(mte_pkg::OP_MEASURE, subs);

    // rotating shaft with jitter; occasional noise frames and recalibration
    shaft = $urandom_range(0, 65535);
    rate  = int'($urandom_range(0, 24000)) - 12000;
    for (int f = 0; f < RAND_FRAMES; f++) begin
      steady = (f >= 10 && f < 16);
      kind = $urandom_range(0, 9);
      for (int k = 0; k < SUBSAMPLES; k++) begin
        if (kind < 2)
          subs[k] = mte_pkg::SAMPLE_W'($urandom_range(0, 65535));
        else
          subs[k] = mte_pkg::SAMPLE_W'(shaft + (rate * k) / SUBSAMPLES
                                       + int'($urandom_range(0, 400)) - 200);
      end
      shaft = shaft + rate;
      if ($urandom_range(0, 3) == 0) rate = int'($urandom_range(0, 24000)) - 12000;
      op = (kind == 9) ? mte_pkg::OP_CALIBRATE : mte_pkg::OP_MEASURE;
      send_frame(op, subs);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    drain = 0;
    while (drain < 30) begin
      @(posedge clk);
      drain++;
    end

    $display("%0d frames (%0d calibrate) of %0d words sent, %0d results checked",
             frames_sent, cal_frames, FRAME_LEN, results_seen);
    $display("directed vote/boundary frames plus random trajectories under stalls");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
